>>> design/srec_pkg.sv
package srec_pkg;

    // ASCII characters the parser looks for
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_1   = 8'h31;
    localparam logic [7:0] CH_2   = 8'h32;
    localparam logic [7:0] CH_3   = 8'h33;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [7:0] CH_LCA = 8'h61;
    localparam logic [7:0] CH_LCF = 8'h66;

    // input op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // configuration space
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_WRITE_LIMIT = 1'b0;
    localparam logic [15:0] WRITE_LIMIT_RESET = 16'h7FFF;

    // address byte counts per record type
    localparam logic [2:0] ABYTES_16 = 3'd2;
    localparam logic [2:0] ABYTES_24 = 3'd3;
    localparam logic [2:0] ABYTES_32 = 3'd4;

    typedef enum logic [2:0] {
        PH_START,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DHI,
        PH_DLO,
        PH_TAIL,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } step_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        loaded;
    } result_t;

    typedef struct packed {
        logic finished;
        logic any_loaded;
    } core_stat_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        case (c) inside
            [CH_0:CH_9]:     h.val = 4'(c - CH_0);
            [CH_UA:CH_UF]:   h.val = 4'(c - CH_UA + 8'd10);
            [CH_LCA:CH_LCF]: h.val = 4'(c - CH_LCA + 8'd10);
            default:         h.ok  = 1'b0;
        endcase
        return h;
    endfunction

endpackage

>>> design/srec_apb_regs.sv
module srec_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srec_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [15:0]                 write_limit
);

    logic [15:0] write_limit_reg;
    logic [15:0] write_limit_next;
    logic        sel_limit;

    // word address selects the register; byte offset ignored
    assign sel_limit = (paddr[srec_pkg::PADDR_W-1:2] == srec_pkg::REG_WRITE_LIMIT);

    always_comb begin
        write_limit_next = write_limit_reg;
        if (psel && penable && pwrite && sel_limit) begin
            write_limit_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_limit_reg <= srec_pkg::WRITE_LIMIT_RESET;
        end else begin
            write_limit_reg <= write_limit_next;
        end
    end

    assign prdata      = sel_limit ? 32'(write_limit_reg) : 32'd0;
    assign pready      = 1'b1;
    assign write_limit = write_limit_reg;

endmodule

>>> design/srec_parse_core.sv
module srec_parse_core #(
    parameter int unsigned ADDRESS_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  srec_pkg::step_t      step,
    input  logic [15:0]          write_limit,
    output srec_pkg::result_t    res,
    output srec_pkg::core_stat_t stat
);

    // only the low 16 address bits ever reach the output
    localparam int unsigned AW = (ADDRESS_BITS < 16) ? ADDRESS_BITS : 16;

    srec_pkg::phase_t phase_reg, phase_next;
    logic [2:0]    abytes_reg, abytes_next;
    logic          term_reg, term_next;
    logic [7:0]    count_reg, count_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [3:0]    high_reg, high_next;
    logic [7:0]    fidx_reg, fidx_next;
    logic          any_reg, any_next;
    logic [AW-1:0] first_reg, first_next;
    logic          finished_reg, finished_next;

    srec_pkg::hex_t hex;
    logic [AW-1:0]  wr_addr;
    logic [15:0]    wr_addr16;
    logic           in_range;
    logic [7:0]     byte_total;
    logic [7:0]     fidx_inc;
    logic           is_lf;
    logic           line_done;
    logic           live;

    // shared decode
    always_comb begin
        hex        = srec_pkg::hex_decode(step.ch);
        wr_addr    = acc_reg + AW'(fidx_reg);
        wr_addr16  = 16'(wr_addr);
        in_range   = (wr_addr16 <= write_limit);
        byte_total = count_reg - {5'd0, abytes_reg} - 8'd1;
        fidx_inc   = fidx_reg + 8'd1;
        is_lf      = (step.ch == srec_pkg::CH_LF);
        line_done  = term_reg && ((phase_reg == srec_pkg::PH_DHI) ||
                                  (phase_reg == srec_pkg::PH_DLO) ||
                                  (phase_reg == srec_pkg::PH_TAIL));
        live       = step_en && !finished_reg;
    end

    // next state
    always_comb begin
        phase_next    = phase_reg;
        abytes_next   = abytes_reg;
        term_next     = term_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;
        high_next     = high_reg;
        fidx_next     = fidx_reg;
        any_next      = any_reg;
        first_next    = first_reg;
        finished_next = finished_reg;
        if (live) begin
            if (step.op == srec_pkg::OP_END) begin
                finished_next = 1'b1;
            end else if (is_lf) begin
                phase_next = srec_pkg::PH_START;
                term_next  = 1'b0;
                if (line_done) begin
                    finished_next = 1'b1;
                end
            end else begin
                case (phase_reg)
                    srec_pkg::PH_START: begin
                        term_next  = 1'b0;
                        phase_next = (step.ch == srec_pkg::CH_S) ? srec_pkg::PH_TYPE
                                                                 : srec_pkg::PH_SKIP;
                    end
                    srec_pkg::PH_TYPE: begin
                        term_next  = (step.ch == srec_pkg::CH_9);
                        count_next = 8'd0;
                        fidx_next  = 8'd0;
                        phase_next = srec_pkg::PH_COUNT;
                        case (step.ch)
                            srec_pkg::CH_1, srec_pkg::CH_9: abytes_next = srec_pkg::ABYTES_16;
                            srec_pkg::CH_2:                 abytes_next = srec_pkg::ABYTES_24;
                            srec_pkg::CH_3:                 abytes_next = srec_pkg::ABYTES_32;
                            default: begin
                                // unknown type: drop the line, keep the rest
                                term_next  = term_reg;
                                count_next = count_reg;
                                fidx_next  = fidx_reg;
                                phase_next = srec_pkg::PH_SKIP;
                            end
                        endcase
                    end
                    srec_pkg::PH_COUNT, srec_pkg::PH_ADDR,
                    srec_pkg::PH_DHI, srec_pkg::PH_DLO: begin
                        if (!hex.ok) begin
                            phase_next = srec_pkg::PH_SKIP;
                            term_next  = 1'b0;
                        end else begin
                            case (phase_reg)
                                srec_pkg::PH_COUNT: begin
                                    count_next = {count_reg[3:0], hex.val};
                                    if (fidx_inc >= 8'd2) begin
                                        fidx_next  = 8'd0;
                                        acc_next   = '0;
                                        phase_next = srec_pkg::PH_ADDR;
                                    end else begin
                                        fidx_next = fidx_inc;
                                    end
                                end
                                srec_pkg::PH_ADDR: begin
                                    acc_next = {acc_reg[AW-5:0], hex.val};
                                    if (fidx_inc >= {4'd0, abytes_reg, 1'b0}) begin
                                        fidx_next  = 8'd0;
                                        phase_next = (count_reg > ({5'd0, abytes_reg} + 8'd1))
                                                   ? srec_pkg::PH_DHI : srec_pkg::PH_TAIL;
                                    end else begin
                                        fidx_next = fidx_inc;
                                    end
                                end
                                srec_pkg::PH_DHI: begin
                                    high_next  = hex.val;
                                    phase_next = srec_pkg::PH_DLO;
                                end
                                default: begin
                                    fidx_next  = fidx_inc;
                                    phase_next = (fidx_inc >= byte_total) ? srec_pkg::PH_TAIL
                                                                          : srec_pkg::PH_DHI;
                                    if (in_range && !any_reg) begin
                                        any_next   = 1'b1;
                                        first_next = wr_addr;
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;  // tail and skip wait for newline
                endcase
            end
        end
    end

    // result
    always_comb begin
        res        = '0;
        res.kind   = srec_pkg::KIND_WRITE;
        if (live) begin
            if ((step.op == srec_pkg::OP_END) || (is_lf && line_done)) begin
                res.valid  = 1'b1;
                res.kind   = srec_pkg::KIND_FINISH;
                res.addr   = 16'(first_reg);
                res.data   = 8'd0;
                res.loaded = any_reg;
            end else if (!is_lf && (phase_reg == srec_pkg::PH_DLO) && hex.ok && in_range) begin
                res.valid  = 1'b1;
                res.kind   = srec_pkg::KIND_WRITE;
                res.addr   = wr_addr16;
                res.data   = {high_reg, hex.val};
                res.loaded = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= srec_pkg::PH_START;
            abytes_reg   <= 3'd0;
            term_reg     <= 1'b0;
            count_reg    <= 8'd0;
            acc_reg      <= '0;
            high_reg     <= 4'd0;
            fidx_reg     <= 8'd0;
            any_reg      <= 1'b0;
            first_reg    <= '0;
            finished_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            abytes_reg   <= abytes_next;
            term_reg     <= term_next;
            count_reg    <= count_next;
            acc_reg      <= acc_next;
            high_reg     <= high_next;
            fidx_reg     <= fidx_next;
            any_reg      <= any_next;
            first_reg    <= first_next;
            finished_reg <= finished_next;
        end
    end

    assign stat.finished   = finished_reg;
    assign stat.any_loaded = any_reg;

endmodule

>>> design/srec_record_loader.sv
// S-record loader: parses Motorola S-record text one character per word and
// turns each data byte into a memory write word.
//
// Input channel (s_*): s_op = 0 carries the character s_ch; s_op = 1 marks end
// of stream. Newline ends a record line. S1/S9 use 16-bit, S2 24-bit and S3
// 32-bit addresses; the checksum field is ignored.
// Output channel (m_*): m_kind = 0 is a write of m_data to m_addr, produced
// only when m_addr <= write_limit. m_kind = 1 is the single finish word (on an
// S9 line or end of stream) carrying the first written address; after it the
// block ignores all input until reset.
// APB port: one register, write_limit at offset 0x0 (reset 0x7FFF). Write it
// only while the block is idle.
// A word's result reaches m_valid through the input register, then the parse
// step into the output register. Throughput: one word per cycle while the
// output register is not stalled.
// A full output register with m_ready low stalls the parse step; the input
// register still takes a word while it is empty, then s_ready drops.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to line start; no clearing pass is needed.
module srec_record_loader #(
    parameter int unsigned ADDRESS_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [7:0]                   s_ch,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [15:0]                  m_addr,
    output logic [7:0]                   m_data,
    output logic                         m_loaded,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srec_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic                 in_valid_reg, in_valid_next;
    srec_pkg::step_t      in_reg, in_next;
    logic                 out_valid_reg, out_valid_next;
    srec_pkg::result_t    out_reg, out_next;
    logic                 advance;
    logic [15:0]          write_limit;
    srec_pkg::result_t    core_res;
    srec_pkg::core_stat_t core_stat;

    srec_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .write_limit (write_limit)
    );

    srec_parse_core #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .step        (in_reg),
        .write_limit (write_limit),
        .res         (core_res),
        .stat        (core_stat)
    );

    // parse the held word once the output register can take its result
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_next.op    = s_op;
            in_next.ch    = s_ch;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            // a step with no result still drains the (taken or empty) slot
            out_valid_next = core_res.valid;
            out_next       = core_res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_kind   = out_reg.kind;
    assign m_addr   = out_reg.addr;
    assign m_data   = out_reg.data;
    assign m_loaded = out_reg.loaded;

    // held input word is not lost or changed while the parse step waits
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("input word lost while stalled");

    // once finished, the parser never produces another word
    a_silent_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.finished |-> !core_res.valid)
        else $error("result after finish");

    // a write word always reports that something has been loaded
    a_write_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && core_res.valid && (core_res.kind == srec_pkg::KIND_WRITE)
        |=> core_stat.any_loaded)
        else $error("write without loaded flag");

    // reset empties both pipeline registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !in_valid_reg)
        else $error("pipeline not empty after reset");

endmodule
